// ===== src/dac_pkg.sv =====
// shared types, constants and cordic helpers for the direction angle converter
// no dependencies; used by every module of the block
package dac_pkg;

   localparam int DAC_ROTATION_STEPS = 16;
   localparam int DAC_TABLE_LEN      = 24;
   localparam int DAC_SQRT_STAGES    = 16;

   localparam logic signed [35:0] DAC_START_GAIN  = 36'sd652032874;
   localparam logic signed [26:0] DAC_QUARTER_ANG = 27'sd4194304;

   typedef enum logic {
      OP_TO_ANGLES = 1'b0,
      OP_TO_VECTOR = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [35:0] cx;
      logic signed [35:0] cy;
      logic signed [26:0] acc;
   } lane_type;

   typedef struct packed {
      opcode_type  mode;
      logic        zero_a;
      logic        neg_a;
      logic        neg_b;
      lane_type    lane_a;
      lane_type    lane_b;
      logic [62:0] rem;
      logic [30:0] root;
   } pipe_type;

   // round(atan(2^-i) * 2^24 / pi)
   function automatic logic signed [26:0] atan_entry(input int idx);
      logic signed [26:0] t;
      case (idx)
         0:       t = 27'sd4194304;
         1:       t = 27'sd2476042;
         2:       t = 27'sd1308273;
         3:       t = 27'sd664100;
         4:       t = 27'sd333339;
         5:       t = 27'sd166832;
         6:       t = 27'sd83436;
         7:       t = 27'sd41721;
         8:       t = 27'sd20861;
         9:       t = 27'sd10430;
         10:      t = 27'sd5215;
         11:      t = 27'sd2608;
         12:      t = 27'sd1304;
         13:      t = 27'sd652;
         14:      t = 27'sd326;
         15:      t = 27'sd163;
         16:      t = 27'sd81;
         17:      t = 27'sd41;
         18:      t = 27'sd20;
         19:      t = 27'sd10;
         20:      t = 27'sd5;
         21:      t = 27'sd3;
         22:      t = 27'sd1;
         23:      t = 27'sd1;
         default: t = 27'sd0;
      endcase
      return t;
   endfunction

   // one micro-rotation; vectoring drives cy to zero, rotation drives acc to zero
   function automatic lane_type cordic_step(input lane_type l, input opcode_type mode,
                                            input int idx);
      lane_type           r;
      logic               sel;
      logic signed [35:0] sx;
      logic signed [35:0] sy;
      logic signed [26:0] t;
      sx  = l.cx >>> idx;
      sy  = l.cy >>> idx;
      t   = atan_entry(idx);
      sel = (mode == OP_TO_VECTOR) ? ~l.acc[26] : l.cy[35];
      if (sel) begin
         r.cx  = l.cx - sy;
         r.cy  = l.cy + sx;
         r.acc = l.acc - t;
      end else begin
         r.cx  = l.cx + sy;
         r.cy  = l.cy - sx;
         r.acc = l.acc + t;
      end
      return r;
   endfunction

endpackage

// ===== src/dac_front.sv =====
// input stage: clamps y, squares it, folds angles and sets up both cordic lanes
// depends on dac_pkg
module dac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               opcode,
   input  logic signed [15:0] in_x,
   input  logic signed [15:0] in_y,
   input  logic signed [15:0] in_z,
   input  logic signed [15:0] in_azimuth,
   input  logic signed [15:0] in_elevation,
   output logic               out_valid,
   output dac_pkg::pipe_type  out_pipe
);
   import dac_pkg::*;

   // {negate, folded angle}
   function automatic logic [17:0] fold_angle(input logic signed [15:0] a);
      logic signed [16:0] w;
      logic               neg;
      w   = {a[15], a};
      neg = 1'b0;
      if (w > 17'sd16384) begin
         w   = w - 17'sd32768;
         neg = 1'b1;
      end else if (w < -17'sd16384) begin
         w   = w + 17'sd32768;
         neg = 1'b1;
      end
      return {neg, w};
   endfunction

   logic               valid_ff;
   pipe_type           pipe_ff;
   pipe_type           pipe_in;
   logic signed [15:0] y_c;
   logic signed [31:0] ysq;
   logic [28:0]        rem29;
   logic signed [35:0] x36;
   logic signed [35:0] z36;
   logic [17:0]        fa;
   logic [17:0]        fe;

   always_comb begin
      pipe_in      = '0;
      pipe_in.mode = opcode_type'(opcode);
      if (in_y > 16'sd16384) y_c = 16'sd16384;
      else if (in_y < -16'sd16384) y_c = -16'sd16384;
      else y_c = in_y;
      ysq   = y_c * y_c;
      rem29 = 29'(32'sd268435456 - ysq);
      x36   = {{4{in_x[15]}}, in_x, 16'b0};
      z36   = {{4{in_z[15]}}, in_z, 16'b0};
      fa    = fold_angle(in_azimuth);
      fe    = fold_angle(in_elevation);
      if (pipe_in.mode == OP_TO_ANGLES) begin
         pipe_in.zero_a = (in_x == 16'sd0) && (in_z == 16'sd0);
         // move a left half-plane vector into the right half-plane first
         if (in_z[15]) begin
            if (!in_x[15]) begin
               pipe_in.lane_a.cx  = x36;
               pipe_in.lane_a.cy  = -z36;
               pipe_in.lane_a.acc = DAC_QUARTER_ANG;
            end else begin
               pipe_in.lane_a.cx  = -x36;
               pipe_in.lane_a.cy  = z36;
               pipe_in.lane_a.acc = -DAC_QUARTER_ANG;
            end
         end else begin
            pipe_in.lane_a.cx  = z36;
            pipe_in.lane_a.cy  = x36;
            pipe_in.lane_a.acc = 27'sd0;
         end
         pipe_in.lane_b.cy = {{4{y_c[15]}}, y_c, 16'b0};
         pipe_in.rem       = {2'b0, rem29, 32'b0};
      end else begin
         pipe_in.neg_a      = fa[17];
         pipe_in.neg_b      = fe[17];
         pipe_in.lane_a.cx  = DAC_START_GAIN;
         pipe_in.lane_a.acc = {{2{fa[16]}}, fa[16:0], 8'b0};
         pipe_in.lane_b.cx  = DAC_START_GAIN;
         pipe_in.lane_b.acc = {{2{fe[16]}}, fe[16:0], 8'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== src/dac_sqrt_stage.sv =====
// one stage of the digit-by-digit square root, two root bits per stage (one when HI_BIT is 0)
// depends on dac_pkg
module dac_sqrt_stage #(
   parameter int HI_BIT = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  dac_pkg::pipe_type in_pipe,
   output logic              out_valid,
   output dac_pkg::pipe_type out_pipe
);
   import dac_pkg::*;

   localparam int LO_BIT = (HI_BIT > 0) ? HI_BIT - 1 : 0;

   logic        valid_ff;
   pipe_type    pipe_ff;
   pipe_type    pipe_in;
   logic [62:0] trial;

   always_comb begin
      pipe_in = in_pipe;
      trial   = '0;
      for (int b = HI_BIT; b >= LO_BIT; b--) begin
         // (root + 2^b)^2 - root^2
         trial = ({32'b0, pipe_in.root} << (b + 1)) + (63'd1 << (2 * b));
         if (pipe_in.rem >= trial) begin
            pipe_in.rem  = pipe_in.rem - trial;
            pipe_in.root = pipe_in.root | (31'd1 << b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== src/dac_cordic_stage.sv =====
// one cordic micro-rotation on both lanes, vectoring or rotating by opcode
// depends on dac_pkg
module dac_cordic_stage #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  dac_pkg::pipe_type in_pipe,
   output logic              out_valid,
   output dac_pkg::pipe_type out_pipe
);
   import dac_pkg::*;

   logic     valid_ff;
   pipe_type pipe_ff;
   pipe_type pipe_in;

   always_comb begin
      pipe_in        = in_pipe;
      pipe_in.lane_a = cordic_step(in_pipe.lane_a, in_pipe.mode, IDX);
      pipe_in.lane_b = cordic_step(in_pipe.lane_b, in_pipe.mode, IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== src/dac_post.sv =====
// output stages: angle rounding, sign fold, products, rounding and saturation
// depends on dac_pkg; its last register is the result register
module dac_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dac_pkg::pipe_type  in_pipe,
   output logic               out_valid,
   output logic signed [15:0] out_azimuth,
   output logic signed [15:0] out_elevation,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y,
   output logic signed [15:0] out_z
);
   import dac_pkg::*;

   function automatic logic signed [15:0] sat_q(input logic signed [39:0] v,
                                                input logic signed [39:0] lo,
                                                input logic signed [39:0] hi);
      logic signed [39:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r[15:0];
   endfunction

   localparam logic signed [39:0] SAT_HALF_LO = -40'sd32768;
   localparam logic signed [39:0] SAT_HALF_HI = 40'sd32767;
   localparam logic signed [39:0] SAT_ONE     = 40'sd16384;

   // stage 1
   logic               v1_ff;
   opcode_type         mode1_ff;
   logic signed [31:0] ca1_ff, sa1_ff, ce1_ff, se1_ff;
   logic signed [15:0] az1_ff, el1_ff;
   logic signed [31:0] ca1_in, sa1_in, ce1_in, se1_in;
   logic signed [15:0] az1_in, el1_in;
   logic signed [35:0] ta, tb, tc, td;
   logic signed [26:0] ra, rb;
   // stage 2
   logic               v2_ff;
   opcode_type         mode2_ff;
   logic signed [63:0] px2_ff, pz2_ff;
   logic signed [15:0] oy2_ff, az2_ff, el2_ff;
   logic signed [32:0] ry;
   logic signed [15:0] oy2_in;
   // stage 3
   logic               v3_ff;
   logic signed [15:0] az3_ff, el3_ff, ox3_ff, oy3_ff, oz3_ff;
   logic signed [15:0] az3_in, el3_in, ox3_in, oy3_in, oz3_in;
   logic signed [63:0] rx, rz;

   always_comb begin
      ta = in_pipe.neg_a ? -in_pipe.lane_a.cx : in_pipe.lane_a.cx;
      tb = in_pipe.neg_a ? -in_pipe.lane_a.cy : in_pipe.lane_a.cy;
      tc = in_pipe.neg_b ? -in_pipe.lane_b.cx : in_pipe.lane_b.cx;
      td = in_pipe.neg_b ? -in_pipe.lane_b.cy : in_pipe.lane_b.cy;
      ca1_in = ta[31:0];
      sa1_in = tb[31:0];
      ce1_in = tc[31:0];
      se1_in = td[31:0];
      ra = (in_pipe.lane_a.acc + 27'sd128) >>> 8;
      rb = (in_pipe.lane_b.acc + 27'sd128) >>> 8;
      az1_in = sat_q(40'(ra), SAT_HALF_LO, SAT_HALF_HI);
      el1_in = sat_q(40'(rb), -SAT_ONE, SAT_ONE);
      // a zero vector has no direction
      if (in_pipe.zero_a) az1_in = 16'sd0;
      if (in_pipe.mode == OP_TO_VECTOR) begin
         az1_in = 16'sd0;
         el1_in = 16'sd0;
      end
   end

   always_comb begin
      ry     = ($signed({se1_ff[31], se1_ff}) + 33'sd32768) >>> 16;
      oy2_in = sat_q(40'(ry), -SAT_ONE, SAT_ONE);
   end

   always_comb begin
      rx     = (px2_ff + 64'sd35184372088832) >>> 46;
      rz     = (pz2_ff + 64'sd35184372088832) >>> 46;
      ox3_in = sat_q(40'(rx), -SAT_ONE, SAT_ONE);
      oz3_in = sat_q(40'(rz), -SAT_ONE, SAT_ONE);
      oy3_in = oy2_ff;
      az3_in = az2_ff;
      el3_in = el2_ff;
      if (mode2_ff == OP_TO_ANGLES) begin
         ox3_in = 16'sd0;
         oy3_in = 16'sd0;
         oz3_in = 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= in_pipe.mode;
         ca1_ff   <= ca1_in;
         sa1_ff   <= sa1_in;
         ce1_ff   <= ce1_in;
         se1_ff   <= se1_in;
         az1_ff   <= az1_in;
         el1_ff   <= el1_in;
         mode2_ff <= mode1_ff;
         px2_ff   <= sa1_ff * ce1_ff;
         pz2_ff   <= ca1_ff * ce1_ff;
         oy2_ff   <= oy2_in;
         az2_ff   <= az1_ff;
         el2_ff   <= el1_ff;
         az3_ff   <= az3_in;
         el3_ff   <= el3_in;
         ox3_ff   <= ox3_in;
         oy3_ff   <= oy3_in;
         oz3_ff   <= oz3_in;
      end
   end

   assign out_valid     = v3_ff;
   assign out_azimuth   = az3_ff;
   assign out_elevation = el3_ff;
   assign out_x         = ox3_ff;
   assign out_y         = oy3_ff;
   assign out_z         = oz3_ff;

endmodule

// ===== src/direction_angle_converter.sv =====
// direction angle converter top level: front stage, square root, cordic, output
// depends on dac_pkg, dac_front, dac_sqrt_stage, dac_cordic_stage, dac_post
//
// Converts a unit vector (x, y, z in Q1.14) to azimuth atan2(x, z) and
// elevation asin(y) as binary angles (opcode 0), or binary angles back to a
// vector (opcode 1). The req_ channel takes one item per valid/ready handshake;
// the rsp_ channel delivers one result item per input item, in order.
// The pipeline has one front stage, 16 square root stages (two root bits each,
// one in the last), one cordic stage per micro-rotation and three output
// stages (rounding, multiply, saturate).
// Throughput is one item per cycle while the output is free; every stage holds one item.
// When rsp_ready is low while a result waits, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated. Empty stages fill while the
// output is free, so the pipeline refills without gaps after a stall.
// Synchronous reset clears all valid bits; the data registers are not reset.
module direction_angle_converter #(
   parameter int ROTATION_STEPS = dac_pkg::DAC_ROTATION_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic signed [15:0] req_in_z,
   input  logic signed [15:0] req_in_azimuth,
   input  logic signed [15:0] req_in_elevation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_azimuth,
   output logic signed [15:0] rsp_out_elevation,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z
);
   import dac_pkg::*;

   localparam int NSTEPS = (ROTATION_STEPS > DAC_TABLE_LEN) ? DAC_TABLE_LEN : ROTATION_STEPS;

   logic     en;
   logic     sq_v [0:DAC_SQRT_STAGES];
   pipe_type sq_p [0:DAC_SQRT_STAGES];
   logic     cd_v [0:NSTEPS];
   pipe_type cd_p [0:NSTEPS];

   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   dac_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .opcode       (req_opcode),
      .in_x         (req_in_x),
      .in_y         (req_in_y),
      .in_z         (req_in_z),
      .in_azimuth   (req_in_azimuth),
      .in_elevation (req_in_elevation),
      .out_valid    (sq_v[0]),
      .out_pipe     (sq_p[0])
   );

   for (genvar k = 0; k < DAC_SQRT_STAGES; k++) begin : g_sqrt
      dac_sqrt_stage #(.HI_BIT(30 - 2 * k)) u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[k]),
         .in_pipe   (sq_p[k]),
         .out_valid (sq_v[k+1]),
         .out_pipe  (sq_p[k+1])
      );
   end

   // elevation lane starts from (sqrt(1 - y^2), y)
   always_comb begin
      cd_v[0] = sq_v[DAC_SQRT_STAGES];
      cd_p[0] = sq_p[DAC_SQRT_STAGES];
      if (sq_p[DAC_SQRT_STAGES].mode == OP_TO_ANGLES) begin
         cd_p[0].lane_b.cx = {5'b0, sq_p[DAC_SQRT_STAGES].root};
      end
   end

   for (genvar i = 0; i < NSTEPS; i++) begin : g_cordic
      dac_cordic_stage #(.IDX(i)) u_cordic (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cd_v[i]),
         .in_pipe   (cd_p[i]),
         .out_valid (cd_v[i+1]),
         .out_pipe  (cd_p[i+1])
      );
   end

   dac_post u_post (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (cd_v[NSTEPS]),
      .in_pipe       (cd_p[NSTEPS]),
      .out_valid     (rsp_valid),
      .out_azimuth   (rsp_out_azimuth),
      .out_elevation (rsp_out_elevation),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .out_z         (rsp_out_z)
   );

endmodule

// ===== bench/direction_angle_converter_tb.sv =====
// testbench for direction_angle_converter: directed and random conversions in both modes
// depends on dac_pkg and the direction_angle_converter rtl; self-checking with its own predictor
`timescale 1ns / 1ps

module direction_angle_converter_tb;
   import dac_pkg::*;

   localparam int STEPS     = 16;
   localparam int LATENCY   = STEPS + 20;
   localparam longint QTURN = 16384;
   localparam longint HTURN = 32768;
   localparam longint ONE   = 16384;
   localparam longint GAIN  = 652032874;

   typedef struct {
      logic signed [15:0] az;
      logic signed [15:0] el;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic signed [15:0] req_in_x;
   logic signed [15:0] req_in_y;
   logic signed [15:0] req_in_z;
   logic signed [15:0] req_in_azimuth;
   logic signed [15:0] req_in_elevation;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_out_azimuth;
   logic signed [15:0] rsp_out_elevation;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;

   result_type pending_results[$];
   int         error_count;
   int         hold_left;
   bit         hold_request;
   int         mode_cycles;
   bit         steady_mode;

   longint atan_units[24] = '{
      4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1
   };

   direction_angle_converter uut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   // vectoring: angle of (cx, cy) in internal units
   function automatic longint angle_of(longint cx, longint cy);
      longint ang;
      longint nx;
      longint ny;
      ang = 0;
      if (cx == 0 && cy == 0) return 0;
      if (cx < 0) begin
         if (cy >= 0) begin
            nx = cy; ny = -cx; ang = QTURN << 8;
         end else begin
            nx = -cy; ny = cx; ang = -(QTURN << 8);
         end
         cx = nx; cy = ny;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i); ny = cy - (cx >>> i); ang += atan_units[i];
         end else begin
            nx = cx - (cy >>> i); ny = cy + (cx >>> i); ang -= atan_units[i];
         end
         cx = nx; cy = ny;
      end
      return ang;
   endfunction

   task automatic rotate_unit(input longint a, output longint c, output longint s);
      longint cx;
      longint cy;
      longint zz;
      longint nx;
      longint ny;
      bit     neg;
      cx  = GAIN;
      cy  = 0;
      neg = 0;
      if (a > QTURN) begin
         a -= HTURN; neg = 1;
      end else if (a < -QTURN) begin
         a += HTURN; neg = 1;
      end
      zz = a * 256;
      for (int i = 0; i < STEPS; i++) begin
         if (zz >= 0) begin
            nx = cx - (cy >>> i); ny = cy + (cx >>> i); zz -= atan_units[i];
         end else begin
            nx = cx + (cy >>> i); ny = cy - (cx >>> i); zz += atan_units[i];
         end
         cx = nx; cy = ny;
      end
      c = neg ? -cx : cx;
      s = neg ? -cy : cy;
   endtask

   task automatic convert_direction(input opcode_type op, input logic signed [15:0] vx,
                                    input logic signed [15:0] vy,
                                    input logic signed [15:0] vz,
                                    input logic signed [15:0] a_az,
                                    input logic signed [15:0] a_el,
                                    output result_type r);
      longint yy;
      longint w;
      longint ca;
      longint sa;
      longint ce;
      longint se;
      r = '{default: '0};
      if (op == OP_TO_ANGLES) begin
         r.az = 16'(clamp((angle_of(longint'(vz) * 65536, longint'(vx) * 65536) + 128) >>> 8,
                          -HTURN, HTURN - 1));
         yy   = clamp(longint'(vy), -ONE, ONE);
         w    = int_sqrt(longint'(ONE * ONE - yy * yy) << 32);
         r.el = 16'(clamp((angle_of(w, yy * 65536) + 128) >>> 8, -QTURN, QTURN));
      end else begin
         rotate_unit(longint'(a_az), ca, sa);
         rotate_unit(longint'(a_el), ce, se);
         r.x = 16'(clamp((sa * ce + (64'sd1 <<< 45)) >>> 46, -ONE, ONE));
         r.y = 16'(clamp((se + 32768) >>> 16, -ONE, ONE));
         r.z = 16'(clamp((ca * ce + (64'sd1 <<< 45)) >>> 46, -ONE, ONE));
      end
   endtask

   // holds valid high; returns after the edge that accepts the item
   task automatic send_item(input opcode_type op, input logic signed [15:0] vx,
                            input logic signed [15:0] vy, input logic signed [15:0] vz,
                            input logic signed [15:0] a_az, input logic signed [15:0] a_el);
      result_type r;
      bit         taken;
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_in_x         <= vx;
      req_in_y         <= vy;
      req_in_z         <= vz;
      req_in_azimuth   <= a_az;
      req_in_elevation <= a_el;
      convert_direction(op, vx, vy, vz, a_az, a_el, r);
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      pending_results.push_back(r);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] rand_unit();
      return 16'($urandom_range(0, 32768)) - 16'sd16384;
   endfunction

   task automatic send_random(input bit wide);
      opcode_type op;
      op = opcode_type'($urandom_range(0, 1));
      if (wide)
         send_item(op, rand16(), rand16(), rand16(), rand16(), rand16());
      else
         send_item(op, rand_unit(), rand_unit(), rand_unit(), rand16(), rand16());
   endtask

   task automatic test_vector_extremes();
      send_item(OP_TO_ANGLES, 0, 0, 0, rand16(), rand16());       // zero vector
      send_item(OP_TO_ANGLES, 0, 0, -16384, 0, 0);                // azimuth of pi
      send_item(OP_TO_ANGLES, 0, 0, 16384, 0, 0);
      send_item(OP_TO_ANGLES, 16384, 0, 0, 0, 0);
      send_item(OP_TO_ANGLES, -16384, 0, 0, 0, 0);
      send_item(OP_TO_ANGLES, 0, 16384, 0, 0, 0);
      send_item(OP_TO_ANGLES, 0, -16384, 0, 0, 0);
      send_item(OP_TO_ANGLES, 0, 16'sh7fff, 0, 0, 0);             // y clamped
      send_item(OP_TO_ANGLES, 0, -16'sh8000, 0, 0, 0);
      send_item(OP_TO_ANGLES, 16'sh7fff, 0, -16'sh8000, 0, 0);    // x, z past one
      send_item(OP_TO_ANGLES, -16'sh8000, 16'sh7fff, 16'sh7fff, -1, -1);
      send_item(OP_TO_ANGLES, 11585, 0, -11585, 0, 0);
      idle_gap(1);
   endtask

   task automatic test_angle_extremes();
      send_item(OP_TO_VECTOR, 0, 0, 0, 0, 0);
      send_item(OP_TO_VECTOR, -1, -1, -1, -16'sh8000, 0);
      send_item(OP_TO_VECTOR, 0, 0, 0, 16'sh7fff, 16'sh7fff);
      send_item(OP_TO_VECTOR, 0, 0, 0, 16384, 16384);
      send_item(OP_TO_VECTOR, 0, 0, 0, 16385, -16385);            // folded by half a turn
      send_item(OP_TO_VECTOR, 0, 0, 0, -16384, -16384);
      send_item(OP_TO_VECTOR, 0, 0, 0, 8192, -16'sh8000);
      send_item(OP_TO_VECTOR, 16'sh7fff, 16'sh7fff, 16'sh7fff, -8192, 4096);
      idle_gap(1);
   endtask

   task automatic test_random_stream(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         for (int b = $urandom_range(1, 20); b > 0 && sent < count; b--) begin
            send_random($urandom_range(0, 3) == 0);
            sent++;
         end
         idle_gap($urandom_range(0, 6));
      end
      idle_gap(1);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int k = 0; k < 80; k++) send_random(1'b0);
      idle_gap(1);
   endtask

   // receiver: alternates random stalls with steady stretches, plus long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_left   = 0;
         mode_cycles = 0;
         steady_mode = 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (mode_cycles == 0) begin
            mode_cycles = $urandom_range(16, 96);
            steady_mode = ($urandom_range(0, 2) == 0);
         end
         mode_cycles--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   // result checker: sample before the edge, compare in order
   always @(negedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result item with nothing expected", $time);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_out_azimuth !== e.az) begin
               $display("%0t: azimuth expected %0d actual %0d", $time, e.az, rsp_out_azimuth);
               error_count++;
            end
            if (rsp_out_elevation !== e.el) begin
               $display("%0t: elevation expected %0d actual %0d", $time, e.el,
                        rsp_out_elevation);
               error_count++;
            end
            if (rsp_out_x !== e.x) begin
               $display("%0t: x expected %0d actual %0d", $time, e.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== e.y) begin
               $display("%0t: y expected %0d actual %0d", $time, e.y, rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== e.z) begin
               $display("%0t: z expected %0d actual %0d", $time, e.z, rsp_out_z);
               error_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[direction_angle_converter] ERROR");
      $finish;
   end

   initial begin
      error_count      = 0;
      hold_request     = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_TO_ANGLES;
      req_in_x         <= '0;
      req_in_y         <= '0;
      req_in_z         <= '0;
      req_in_azimuth   <= '0;
      req_in_elevation <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_vector_extremes();
      test_angle_extremes();
      test_random_stream(200);
      test_backpressure();
      test_random_stream(170);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("[direction_angle_converter] OK");
      else
         $display("[direction_angle_converter] ERROR");
      $finish;
   end

endmodule
